FILE: rtl/core/utli_pkg.sv
`timescale 1ns / 1ps
// Package for the uniform table linear interpolation unit.
// Holds command codes, configuration register indexes and reset values.
// No dependencies.
package utli_pkg;

    localparam int MAX_ENTRIES_DEFAULT = 1024;

    localparam int DATA_W = 32;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int FRAC_W = 16;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_LOOKUP = 1'b1
    } command_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MIN_VALUE = 2'd0,
        REG_MAX_VALUE = 2'd1,
        REG_BIN_SCALE = 2'd2,
        REG_ENTRIES_USED = 2'd3
    } cfg_reg_t;

    localparam logic [DATA_W-1:0] MIN_VALUE_RESET = 32'h0000_0000;
    localparam logic [DATA_W-1:0] MAX_VALUE_RESET = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] BIN_SCALE_RESET = 32'h0001_0000;
    localparam logic [COUNT_W-1:0] ENTRIES_USED_RESET = 11'd1024;

endpackage

FILE: rtl/core/uniform_table_linear_interp_unit.sv
`timescale 1ns / 1ps
// Uniform table linear interpolation unit, top level.
// One request per cycle is accepted while in_stall is low.
// The sample table is one synchronous memory with one write and two read ports.
// The pipeline pauses only while the output skid register holds a result.
// Reset clears the pipeline and sets the registers; the table is undefined until loaded.
module uniform_table_linear_interp_unit
    import utli_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     command,
    input  logic [INDEX_W-1:0]       entry_index,
    input  logic signed [DATA_W-1:0] entry_value,
    input  logic signed [DATA_W-1:0] sample,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] value
);

    localparam int AW = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int NW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int PW = 2 * DATA_W - FRAC_W;
    localparam int SW = 2 * DATA_W - 13;

    logic [DATA_W-1:0]  min_value_reg;
    logic [DATA_W-1:0]  max_value_reg;
    logic [DATA_W-1:0]  bin_scale_reg;
    logic [COUNT_W-1:0] entries_used_reg;

    logic [DATA_W-1:0] sample_table [MAX_ENTRIES];

    logic en;
    logic accept;

    logic              v1_reg, look1_reg, below1_reg, above1_reg, ld_ok1_reg;
    logic [AW-1:0]     waddr1_reg;
    logic [DATA_W-1:0] wdata1_reg;
    logic [DATA_W-1:0] off1_reg;

    logic              v2_reg, look2_reg, below2_reg, above2_reg, ld_ok2_reg;
    logic [AW-1:0]     waddr2_reg;
    logic [DATA_W-1:0] wdata2_reg;
    logic [PW-1:0]     pos2_reg;

    logic              v3_reg;
    logic [FRAC_W-1:0] frac3_reg;
    logic [DATA_W-1:0] rd_a_reg;
    logic [DATA_W-1:0] rd_b_reg;

    logic                      v4_reg;
    logic signed [SW-1:0]      prod_a4_reg;
    logic signed [SW-1:0]      prod_b4_reg;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [DATA_W-1:0] skid_reg, skid_next;

    logic [NW-1:0]     n_raw, n_eff;
    logic [AW-1:0]     last_idx;
    logic [DATA_W-1:0] last_ext;
    logic [DATA_W-1:0] idx_ext;
    logic              ld_ok0;
    logic [DATA_W-1:0] bin2;
    logic [AW-1:0]     addr_a, addr_b;
    logic [FRAC_W-1:0] frac_sel;
    logic [2*DATA_W-1:0] pos_full;
    logic signed [SW-1:0] sum4;
    logic signed [SW-FRAC_W-1:0] quot4;
    logic [DATA_W-1:0] result4;
    logic              take;

    assign en = !skid_valid_reg;
    assign in_stall = skid_valid_reg;
    assign accept = in_valid && en;

    // Effective entry count and index of the last entry.
    always_comb
    begin
        n_raw = NW'(entries_used_reg);
        if (n_raw < NW'(2))
        begin
            n_eff = NW'(2);
        end
        else if (n_raw > NW'(MAX_ENTRIES))
        begin
            n_eff = NW'(MAX_ENTRIES);
        end
        else
        begin
            n_eff = n_raw;
        end
        last_idx = AW'(n_eff - NW'(1));
        last_ext = DATA_W'(last_idx);
    end

    assign idx_ext = DATA_W'(entry_index);
    assign ld_ok0 = idx_ext < DATA_W'(MAX_ENTRIES);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_value_reg <= MIN_VALUE_RESET;
            max_value_reg <= MAX_VALUE_RESET;
            bin_scale_reg <= BIN_SCALE_RESET;
            entries_used_reg <= ENTRIES_USED_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MIN_VALUE:    min_value_reg <= cfg_data;
                REG_MAX_VALUE:    max_value_reg <= cfg_data;
                REG_BIN_SCALE:    bin_scale_reg <= cfg_data;
                REG_ENTRIES_USED: entries_used_reg <= cfg_data[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg && look2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Stage one: bound tests and offset from the lower bound.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            look1_reg <= (command_t'(command) == CMD_LOOKUP);
            below1_reg <= (sample <= $signed(min_value_reg));
            above1_reg <= (sample >= $signed(max_value_reg));
            off1_reg <= sample - $signed(min_value_reg);
            ld_ok1_reg <= ld_ok0;
            waddr1_reg <= idx_ext[AW-1:0];
            wdata1_reg <= entry_value;
        end
    end

    // Stage two: position in the table as offset times bin scale.
    assign pos_full = {{DATA_W{1'b0}}, off1_reg} * {{DATA_W{1'b0}}, bin_scale_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            look2_reg <= look1_reg;
            below2_reg <= below1_reg;
            above2_reg <= above1_reg;
            ld_ok2_reg <= ld_ok1_reg;
            waddr2_reg <= waddr1_reg;
            wdata2_reg <= wdata1_reg;
            pos2_reg <= pos_full[2*DATA_W-1:FRAC_W];
        end
    end

    // Stage three: table addresses, then the memory access.
    assign bin2 = pos2_reg[PW-1:FRAC_W];

    always_comb
    begin
        addr_a = '0;
        addr_b = '0;
        frac_sel = '0;
        if (below2_reg)
        begin
            addr_a = '0;
            addr_b = '0;
        end
        else if (above2_reg || (bin2 >= last_ext))
        begin
            addr_a = last_idx;
            addr_b = last_idx;
        end
        else
        begin
            addr_a = bin2[AW-1:0];
            addr_b = bin2[AW-1:0] + AW'(1);
            frac_sel = pos2_reg[FRAC_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && v2_reg && !look2_reg && ld_ok2_reg)
        begin
            sample_table[waddr2_reg] <= wdata2_reg;
        end
        if (en)
        begin
            rd_a_reg <= sample_table[addr_a];
            rd_b_reg <= sample_table[addr_b];
            frac3_reg <= frac_sel;
        end
    end

    // Stage four: weight both neighbors.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_a4_reg <= SW'($signed(rd_a_reg))
                * SW'($signed({2'b00, 17'h1_0000 - {1'b0, frac3_reg}}));
            prod_b4_reg <= SW'($signed(rd_b_reg)) * SW'($signed({1'b0, frac3_reg}));
        end
    end

    // Stage five: sum, floor division by 2^16 and saturation.
    always_comb
    begin
        sum4 = prod_a4_reg + prod_b4_reg;
        quot4 = sum4[SW-1:FRAC_W];
        if (quot4 > (SW-FRAC_W)'(33'sh0_7FFF_FFFF))
        begin
            result4 = 32'h7FFF_FFFF;
        end
        else if (quot4 < -(SW-FRAC_W)'(33'sh0_8000_0000))
        begin
            result4 = 32'h8000_0000;
        end
        else
        begin
            result4 = quot4[DATA_W-1:0];
        end
    end

    // Output register with a skid register behind it.
    assign take = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        value_next = value_reg;
        skid_valid_next = skid_valid_reg;
        skid_next = skid_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                value_next = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (v4_reg)
        begin
            if (!out_valid_reg || take)
            begin
                value_next = result4;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next = result4;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_valid_reg;
    assign value = $signed(value_reg);

endmodule

FILE: tb/uniform_table_linear_interp_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for uniform_table_linear_interp_unit: random table loads and lookups
// with random idling, checked in order against a Q16.16 predictor. Depends on utli_pkg and the RTL.
import utli_pkg::*;

class interp_scoreboard;
    logic signed [DATA_W-1:0] lo_bound;
    logic signed [DATA_W-1:0] hi_bound;
    logic [DATA_W-1:0] bin_scale;
    logic [COUNT_W-1:0] count_reg;
    logic signed [DATA_W-1:0] entries [MAX_ENTRIES_DEFAULT];
    bit loaded [MAX_ENTRIES_DEFAULT];
    logic signed [DATA_W-1:0] expected_values [$];
    int errors;

    function new();
        lo_bound = MIN_VALUE_RESET;
        hi_bound = MAX_VALUE_RESET;
        bin_scale = BIN_SCALE_RESET;
        count_reg = ENTRIES_USED_RESET;
        errors = 0;
        foreach (loaded[i]) begin
            loaded[i] = 1'b0;
            entries[i] = '0;
        end
    endfunction

    function void set_register(cfg_reg_t r, logic [DATA_W-1:0] d);
        case (r)
            REG_MIN_VALUE: lo_bound = d;
            REG_MAX_VALUE: hi_bound = d;
            REG_BIN_SCALE: bin_scale = d;
            REG_ENTRIES_USED: count_reg = d[COUNT_W-1:0];
            default: ;
        endcase
    endfunction

    function int entry_count();
        int n;
        n = int'(count_reg);
        if (n < 2) n = 2;
        if (n > MAX_ENTRIES_DEFAULT) n = MAX_ENTRIES_DEFAULT;
        return n;
    endfunction

    // Finds the two entries blended for a sample; clamped cases use one entry twice.
    function void locate(logic signed [DATA_W-1:0] s, output int ia, output int ib,
                         output int frac);
        longint unsigned offset;
        longint unsigned scale_wide;
        longint unsigned pos;
        longint unsigned bin;
        int n;
        n = entry_count();
        ia = 0;
        ib = 0;
        frac = 0;
        if (s <= lo_bound) return;
        if (s >= hi_bound) begin
            ia = n - 1;
            ib = n - 1;
            return;
        end
        offset = longint'(s) - longint'(lo_bound);
        scale_wide = longint'(bin_scale);
        pos = offset * scale_wide;
        bin = pos >> 32;
        frac = int'(pos[31:16]);
        if (bin >= n - 1) begin
            ia = n - 1;
            ib = n - 1;
            frac = 0;
        end
        else begin
            ia = int'(bin);
            ib = ia + 1;
        end
    endfunction

    function int unloaded_entry(logic signed [DATA_W-1:0] s);
        int ia;
        int ib;
        int frac;
        locate(s, ia, ib, frac);
        if (!loaded[ia]) return ia;
        if (!loaded[ib]) return ib;
        return -1;
    endfunction

    // The blend is a convex combination of two entries, so it never leaves the 32-bit range.
    function logic signed [DATA_W-1:0] interpolate(logic signed [DATA_W-1:0] s);
        int ia;
        int ib;
        int frac;
        longint acc;
        locate(s, ia, ib, frac);
        acc = longint'(entries[ia]) * (65536 - frac) + longint'(entries[ib]) * frac;
        acc = acc >>> FRAC_W;
        return acc[DATA_W-1:0];
    endfunction

    function void note_request(command_t cmd, logic [INDEX_W-1:0] idx,
                               logic signed [DATA_W-1:0] val, logic signed [DATA_W-1:0] smp);
        if (cmd == CMD_LOAD) begin
            entries[idx] = val;
            loaded[idx] = 1'b1;
        end
        else begin
            expected_values.push_back(interpolate(smp));
        end
    endfunction

    function void check_value(logic signed [DATA_W-1:0] v);
        logic signed [DATA_W-1:0] want;
        if (expected_values.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %h", $time, v);
            return;
        end
        want = expected_values.pop_front();
        if (v !== want) begin
            errors++;
            $display("%0t: value mismatch, expected %h, actual %h", $time, want, v);
        end
    endfunction

    function int pending();
        return expected_values.size();
    endfunction
endclass

module uniform_table_linear_interp_unit_tb;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASES = 10;
    localparam int PHASE_ITEMS = 65;
    localparam int TABLE_DEPTH = MAX_ENTRIES_DEFAULT;
    localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic command;
    logic [INDEX_W-1:0] entry_index;
    logic signed [DATA_W-1:0] entry_value;
    logic signed [DATA_W-1:0] sample;
    logic out_valid;
    logic out_stall;
    logic signed [DATA_W-1:0] value;

    interp_scoreboard sb;
    int gap_max;
    int stall_max;
    int stall_left;
    int cycles = 0;

    uniform_table_linear_interp_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .entry_index(entry_index),
        .entry_value(entry_value),
        .sample(sample),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .value(value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Each accepted result is followed by a random number of stalled cycles.
    initial
    begin
        out_stall <= 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                sb.check_value(value);
                stall_left = $urandom_range(0, stall_max);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic write_config(logic [DATA_W-1:0] lo, logic [DATA_W-1:0] hi,
                                logic [DATA_W-1:0] sc, logic [DATA_W-1:0] cnt);
        logic [DATA_W-1:0] words [4];
        cfg_reg_t regs [4];
        words = '{lo, hi, sc, cnt};
        regs = '{REG_MIN_VALUE, REG_MAX_VALUE, REG_BIN_SCALE, REG_ENTRIES_USED};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= words[i];
            sb.set_register(regs[i], words[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_request(command_t cmd, logic [INDEX_W-1:0] idx,
                                logic [DATA_W-1:0] val, logic [DATA_W-1:0] smp);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        entry_index <= idx;
        entry_value <= val;
        sample <= smp;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_request(cmd, idx, val, smp);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] draw_entry();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            default: return $urandom;
        endcase
    endfunction

    // Mostly samples inside the domain, with the bounds and the full range mixed in.
    function automatic logic [DATA_W-1:0] draw_sample();
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        longint span;
        longint unsigned r;
        lo = sb.lo_bound;
        hi = sb.hi_bound;
        span = longint'(sb.hi_bound) - longint'(sb.lo_bound);
        r = {$urandom, $urandom};
        case ($urandom_range(0, 19))
            0: return $urandom;
            1: return lo;
            2: return hi;
            3: return lo + 1;
            4: return hi - 1;
            5: return 32'h8000_0000;
            6: return 32'h7FFF_FFFF;
            default: ;
        endcase
        if (span <= 0) return $urandom;
        return DATA_W'(lo + r % span);
    endfunction

    // Usually a domain whose bin scale spans the used entries; sometimes an inverted domain,
    // the full signed range, a zero or maximum scale, or an entry count out of range.
    task automatic random_phase_config();
        int pick;
        int n_raw;
        int n_eff;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] sc;
        longint span;
        longint sc_wide;
        pick = $urandom_range(0, 9);
        if (pick < 7) n_raw = $urandom_range(2, 33);
        else if (pick == 7) n_raw = TABLE_DEPTH;
        else if (pick == 8) n_raw = $urandom_range(34, 300);
        else if ($urandom_range(0, 1) == 0) n_raw = $urandom_range(0, 1);
        else n_raw = $urandom_range(TABLE_DEPTH + 1, 2047);
        n_eff = (n_raw < 2) ? 2 : ((n_raw > TABLE_DEPTH) ? TABLE_DEPTH : n_raw);
        pick = $urandom_range(0, 9);
        lo = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        if ($urandom_range(0, 3) == 0) span = longint'($urandom_range(1, 64));
        else span = longint'($urandom_range(1, 32'h0100_0000));
        if (pick == 6)
        begin
            lo = 32'h8000_0000;
            span = 64'hFFFF_FFFF;
        end
        hi = lo + span[DATA_W-1:0];
        if (pick == 7) hi = lo - $urandom_range(0, 32'h0010_0000);
        sc_wide = (longint'(n_eff - 1) << 32) / span;
        if ($urandom_range(0, 3) == 0) sc_wide = sc_wide + (sc_wide >> 3) + 1;
        if (sc_wide > 64'hFFFF_FFFF) sc_wide = 64'hFFFF_FFFF;
        sc = sc_wide[DATA_W-1:0];
        if (pick == 7) sc = $urandom;
        if (pick == 8) sc = '0;
        if (pick == 9) sc = '1;
        write_config(lo, hi, sc, ($urandom & ~32'h7FF) | n_raw);
    endtask

    initial
    begin
        int miss;
        int pause_at;
        logic [DATA_W-1:0] smp;
        sb = new();
        gap_max = 13;
        stall_max = 13;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_MIN_VALUE;
        cfg_data <= '0;
        in_valid <= 1'b0;
        command <= CMD_LOAD;
        entry_index <= '0;
        entry_value <= '0;
        sample <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Five entries over [-2, 2) holding the value extremes, then bounds and bin edges.
        write_config(32'hFFFE_0000, 32'h0002_0000, Q_ONE, 32'd5);
        send_request(CMD_LOAD, 10'd0, 32'h7FFF_FFFF, $urandom);
        send_request(CMD_LOAD, 10'd1, 32'h8000_0000, $urandom);
        send_request(CMD_LOAD, 10'd2, 32'h0000_0000, $urandom);
        send_request(CMD_LOAD, 10'd3, 32'h7FFF_FFFF, $urandom);
        send_request(CMD_LOAD, 10'd4, 32'h8000_0000, $urandom);
        send_request(CMD_LOAD, 10'd1023, 32'h0003_8000, $urandom);
        send_request(CMD_LOOKUP, INDEX_W'($urandom), $urandom, 32'h8000_0000);
        send_request(CMD_LOOKUP, INDEX_W'($urandom), $urandom, 32'h7FFF_FFFF);
        send_request(CMD_LOOKUP, INDEX_W'($urandom), $urandom, 32'hFFFE_0000);
        send_request(CMD_LOOKUP, INDEX_W'($urandom), $urandom, 32'h0002_0000);
        send_request(CMD_LOOKUP, INDEX_W'($urandom), $urandom, 32'hFFFE_0001);
        send_request(CMD_LOOKUP, INDEX_W'($urandom), $urandom, 32'hFFFF_8000);
        send_request(CMD_LOOKUP, INDEX_W'($urandom), $urandom, 32'h0001_FFFF);
        drain_results();

        // Full signed domain, maximum scale, and an entry count that acts as two.
        write_config(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        send_request(CMD_LOOKUP, INDEX_W'($urandom), $urandom, 32'h8000_0000);
        send_request(CMD_LOOKUP, INDEX_W'($urandom), $urandom, 32'h8000_0001);
        send_request(CMD_LOOKUP, INDEX_W'($urandom), $urandom, 32'h0000_0000);
        send_request(CMD_LOOKUP, INDEX_W'($urandom), $urandom, 32'h7FFF_FFFF);
        drain_results();

        // Inverted domain with an entry count above the table size.
        write_config(Q_ONE, 32'hFFFF_0000, Q_ONE, 32'd2047);
        send_request(CMD_LOOKUP, INDEX_W'($urandom), $urandom, 32'h0003_0000);
        send_request(CMD_LOOKUP, INDEX_W'($urandom), $urandom, 32'h0000_0000);
        send_request(CMD_LOOKUP, INDEX_W'($urandom), $urandom, Q_ONE);
        drain_results();

        // Zero bin scale over the whole table.
        write_config(32'hFFFE_0000, 32'h0002_0000, 32'h0000_0000, 32'd1024);
        send_request(CMD_LOOKUP, INDEX_W'($urandom), $urandom, Q_ONE);
        send_request(CMD_LOOKUP, INDEX_W'($urandom), $urandom, 32'h0002_0000);
        drain_results();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            random_phase_config();
            case ($urandom_range(0, 3))
                0: begin gap_max = 0; stall_max = 0; end
                1: begin gap_max = 13; stall_max = 13; end
                2: begin gap_max = 0; stall_max = 13; end
                default: begin gap_max = 13; stall_max = 0; end
            endcase
            pause_at = (ph == 3) ? $urandom_range(10, 50) : -1;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k == pause_at) drain_results();
                if ($urandom_range(0, 99) < 30)
                begin
                    if ($urandom_range(0, 1) == 0)
                        send_request(CMD_LOAD,
                                     INDEX_W'($urandom_range(0, sb.entry_count() - 1)),
                                     draw_entry(), $urandom);
                    else
                        send_request(CMD_LOAD, INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                                     draw_entry(), $urandom);
                end
                else
                begin
                    smp = draw_sample();
                    miss = sb.unloaded_entry(smp);
                    if (miss >= 0)
                        send_request(CMD_LOAD, miss[INDEX_W-1:0], draw_entry(), $urandom);
                    else
                        send_request(CMD_LOOKUP, INDEX_W'($urandom), $urandom, smp);
                end
            end
            drain_results();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

FILE: uniform_table_linear_interp_unit.f
rtl/core/utli_pkg.sv
rtl/core/uniform_table_linear_interp_unit.sv
tb/uniform_table_linear_interp_unit_tb.sv
